// ----- hdl/sdcw_pkg.sv -----
// Shared types, command codes and the per-index flag table of the SD command word encoder.
`timescale 1ns / 1ps
package sdcw_pkg;

  // Command transfer word bit fields
  localparam int unsigned CwIdxShift = 24;
  localparam logic [31:0] CW_ISDATA  = 32'h0020_0000;
  localparam logic [31:0] CW_IXCHK   = 32'h0010_0000;
  localparam logic [31:0] CW_CRCCHK  = 32'h0008_0000;
  localparam logic [31:0] CW_R136    = 32'h0001_0000;
  localparam logic [31:0] CW_R48     = 32'h0002_0000;
  localparam logic [31:0] CW_R48B    = 32'h0003_0000;
  localparam logic [31:0] CW_MULTI   = 32'h0000_0020;
  localparam logic [31:0] CW_RD      = 32'h0000_0010;
  localparam logic [31:0] CW_BCNTEN  = 32'h0000_0002;
  localparam logic [31:0] CW_DMAEN   = 32'h0000_0001;
  localparam logic [31:0] CW_CHK     = CW_IXCHK | CW_CRCCHK;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [5:0] CMD_IO_OP_COND   = 6'd5;
  localparam logic [5:0] CMD_SWITCH       = 6'd6;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_IF_COND      = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_VOLT_SWITCH  = 6'd11;
  localparam logic [5:0] CMD_STOP         = 6'd12;
  localparam logic [5:0] CMD_STATUS       = 6'd13;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
  localparam logic [5:0] CMD_SD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_IO_RW_DIRECT = 6'd52;
  localparam logic [5:0] CMD_IO_RW_EXT    = 6'd53;
  localparam logic [5:0] CMD_APP          = 6'd55;

  // Argument patterns
  localparam logic [31:0] SWITCH_HS_MASK  = 32'h8000_000F;
  localparam logic [31:0] SWITCH_HS_MATCH = 32'h8000_0001;
  localparam logic [31:0] BUS_IF_MASK     = 32'hFFFF_FF00;
  localparam logic [31:0] BUS_IF_MATCH    = 32'h8000_0E00;
  localparam logic [31:0] APP_WIDTH_1BIT  = 32'd0;
  localparam logic [31:0] APP_WIDTH_4BIT  = 32'd2;
  localparam logic [15:0] ONE_BLOCK       = 16'd1;

  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_R136 = 2'd1,
    RESP_R48  = 2'd2,
    RESP_R48B = 2'd3
  } resp_kind_e;

  typedef enum logic [1:0] {
    WIDTH_KEEP = 2'd0,
    WIDTH_1BIT = 2'd1,
    WIDTH_4BIT = 2'd2
  } width_act_e;

  typedef enum logic [1:0] {
    CLOCK_KEEP  = 2'd0,
    CLOCK_INIT  = 2'd1,
    CLOCK_STD   = 2'd2,
    CLOCK_HIGH  = 2'd3
  } clock_act_e;

  typedef struct packed {
    logic [31:0] command_word;
    logic        supported;
    resp_kind_e  response_kind;
    logic        uses_data_line;
    width_act_e  width_action;
    clock_act_e  clock_action;
  } cmd_result_t;

  function automatic logic [31:0] cw_flags(input logic [5:0] idx);
    logic [31:0] f;
    f = '0;
    case (idx)
      CMD_GO_IDLE:      f = CW_IXCHK;
      CMD_ALL_SEND_CID: f = CW_R136;
      CMD_SEND_RCA:     f = CW_R48 | CW_CHK;
      CMD_IO_OP_COND:   f = CW_R48;
      CMD_SWITCH:       f = CW_R48 | CW_CHK;
      CMD_SELECT:       f = CW_R48B | CW_CHK;
      CMD_IF_COND:      f = CW_R48 | CW_CHK;
      CMD_SEND_CSD:     f = CW_R136;
      CMD_VOLT_SWITCH:  f = CW_R48 | CW_CHK;
      CMD_STOP:         f = CW_R48B | CW_CHK;
      CMD_STATUS:       f = CW_R48 | CW_CHK;
      CMD_SET_BLOCKLEN: f = CW_R48;
      CMD_READ_SINGLE:  f = CW_R48 | CW_ISDATA | CW_RD | CW_CHK;
      CMD_READ_MULTI:   f = CW_R48 | CW_ISDATA | CW_RD | CW_MULTI | CW_BCNTEN | CW_CHK;
      CMD_WRITE_SINGLE: f = CW_R48 | CW_ISDATA | CW_CHK;
      CMD_WRITE_MULTI:  f = CW_R48 | CW_ISDATA | CW_MULTI | CW_BCNTEN | CW_CHK;
      CMD_SD_OP_COND:   f = CW_R48;
      CMD_IO_RW_DIRECT: f = CW_R48 | CW_CHK;
      CMD_IO_RW_EXT:    f = CW_R48 | CW_CHK | CW_ISDATA;
      CMD_APP:          f = CW_R48 | CW_CHK;
      default:          f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/sdcw_decode.sv -----
// Combinational decode of one SD command into its transfer word and follow-up actions.
`timescale 1ns / 1ps
module sdcw_decode import sdcw_pkg::*; (
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] argument_i,
  input  logic [15:0] block_count_i,
  input  logic        app_prefix_i,
  output cmd_result_t result_o
);

  logic [31:0] flags;
  logic [31:0] word;
  width_act_e  wact;
  clock_act_e  cact;

  always_comb begin
    flags = cw_flags(cmd_index_i);
    word  = ({26'd0, cmd_index_i} << CwIdxShift) | flags;
    // Switch function: no app prefix makes CMD6 a data read
    if (cmd_index_i == CMD_SWITCH && !app_prefix_i) begin
      word = word | CW_ISDATA | CW_RD;
    end
    if ((word & CW_ISDATA) != '0) begin
      word = word | CW_DMAEN;
    end
    if (cmd_index_i == CMD_IO_RW_EXT) begin
      if (!argument_i[31]) begin
        word = word | CW_RD;
      end
      if (block_count_i != ONE_BLOCK) begin
        word = word | CW_MULTI | CW_BCNTEN;
      end
    end

    wact = WIDTH_KEEP;
    cact = CLOCK_KEEP;
    if (cmd_index_i == CMD_GO_IDLE) begin
      cact = CLOCK_INIT;
    end else if (cmd_index_i == CMD_SELECT) begin
      cact = CLOCK_STD;
    end

    if (cmd_index_i == CMD_SWITCH) begin
      if (app_prefix_i) begin
        if (argument_i == APP_WIDTH_1BIT) begin
          wact = WIDTH_1BIT;
        end else if (argument_i == APP_WIDTH_4BIT) begin
          wact = WIDTH_4BIT;
        end
      end else if ((argument_i & SWITCH_HS_MASK) == SWITCH_HS_MATCH) begin
        cact = CLOCK_HIGH;
      end
    end else if (cmd_index_i == CMD_IO_RW_DIRECT &&
                 (argument_i & BUS_IF_MASK) == BUS_IF_MATCH) begin
      case (argument_i[1:0])
        2'd0:    wact = WIDTH_1BIT;
        2'd2:    wact = WIDTH_4BIT;
        default: wact = WIDTH_KEEP;
      endcase
    end

    if (flags == '0) begin
      result_o = '0;
    end else begin
      result_o.command_word   = word;
      result_o.supported      = 1'b1;
      result_o.response_kind  = resp_kind_e'(word[17:16]);
      result_o.uses_data_line = word[21] | (word[17:16] == RESP_R48B);
      result_o.width_action   = wact;
      result_o.clock_action   = cact;
    end
  end

endmodule

// ----- hdl/sd_command_word_encoder_top.sv -----
// Top level of the SD command word encoder: input register, decode, result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command: index, argument
//   and the block count currently programmed. Output channel
//   (out_valid_o/out_ready_i) returns one result per command: transfer word,
//   supported flag, response kind, data line use, bus width and clock action.
//   Each command passes through the input register and then the result
//   register; result valid rises when the result register loads it.
//   Throughput is one command per cycle while the receiver does not stall;
//   the decode is a table lookup and a few compares between the two
//   registers, and the one-bit app prefix flag is updated as each command
//   moves into the result register, so back-to-back commands see it in order.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more command, then in_ready_o drops until the result
//   moves on. An unsupported index gives an all-zero result and leaves the
//   prefix flag alone. Reset empties both registers and clears the prefix flag.
module sd_command_word_encoder_top import sdcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] argument_i,
  input  logic [15:0] block_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] command_word_o,
  output logic        supported_o,
  output logic [1:0]  response_kind_o,
  output logic        uses_data_line_o,
  output logic [1:0]  width_action_o,
  output logic [1:0]  clock_action_o
);

  logic        in_valid_q;
  logic [5:0]  idx_q;
  logic [31:0] arg_q;
  logic [15:0] cnt_q;
  logic        out_valid_q;
  cmd_result_t res_q;
  cmd_result_t res_d;
  logic        prefix_q;
  logic        prefix_d;
  logic        advance;
  logic        in_xfer;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  sdcw_decode u_decode (
    .cmd_index_i   (idx_q),
    .argument_i    (arg_q),
    .block_count_i (cnt_q),
    .app_prefix_i  (prefix_q),
    .result_o      (res_d)
  );

  // Unsupported commands leave the prefix flag unchanged
  assign prefix_d = res_d.supported ? (idx_q == CMD_APP) : prefix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prefix_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        prefix_q    <= prefix_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q <= cmd_index_i;
      arg_q <= argument_i;
      cnt_q <= block_count_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_word_o   = res_q.command_word;
  assign supported_o      = res_q.supported;
  assign response_kind_o  = res_q.response_kind;
  assign uses_data_line_o = res_q.uses_data_line;
  assign width_action_o   = res_q.width_action;
  assign clock_action_o   = res_q.clock_action;

endmodule

// ----- bench/sdcw_checker.sv -----
// Result checker for the SD command word encoder: predicts each result and compares it.
`timescale 1ns / 1ps
module sdcw_checker import sdcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] argument_i,
  input  logic [15:0] block_count_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] command_word_i,
  input  logic        supported_i,
  input  logic [1:0]  response_kind_i,
  input  logic        uses_data_line_i,
  input  logic [1:0]  width_action_i,
  input  logic [1:0]  clock_action_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  cmd_result_t expected_results[$];
  logic        app_prefix = 1'b0;
  int unsigned mismatches = 0;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // Expected result of one command, given whether the previous supported command was CMD55.
  function automatic cmd_result_t encode_command(input logic [5:0]  idx,
                                                 input logic [31:0] arg,
                                                 input logic [15:0] cnt,
                                                 input logic        after_app);
    cmd_result_t res;
    logic [31:0] flags;
    logic [31:0] word;
    res = '0;
    case (idx)
      CMD_GO_IDLE:      flags = CW_IXCHK;
      CMD_ALL_SEND_CID: flags = CW_R136;
      CMD_SEND_RCA:     flags = CW_R48 | CW_CHK;
      CMD_IO_OP_COND:   flags = CW_R48;
      CMD_SWITCH:       flags = CW_R48 | CW_CHK;
      CMD_SELECT:       flags = CW_R48B | CW_CHK;
      CMD_IF_COND:      flags = CW_R48 | CW_CHK;
      CMD_SEND_CSD:     flags = CW_R136;
      CMD_VOLT_SWITCH:  flags = CW_R48 | CW_CHK;
      CMD_STOP:         flags = CW_R48B | CW_CHK;
      CMD_STATUS:       flags = CW_R48 | CW_CHK;
      CMD_SET_BLOCKLEN: flags = CW_R48;
      CMD_READ_SINGLE:  flags = CW_R48 | CW_ISDATA | CW_RD | CW_CHK;
      CMD_READ_MULTI:   flags = CW_R48 | CW_ISDATA | CW_RD | CW_MULTI | CW_BCNTEN | CW_CHK;
      CMD_WRITE_SINGLE: flags = CW_R48 | CW_ISDATA | CW_CHK;
      CMD_WRITE_MULTI:  flags = CW_R48 | CW_ISDATA | CW_MULTI | CW_BCNTEN | CW_CHK;
      CMD_SD_OP_COND:   flags = CW_R48;
      CMD_IO_RW_DIRECT: flags = CW_R48 | CW_CHK;
      CMD_IO_RW_EXT:    flags = CW_R48 | CW_CHK | CW_ISDATA;
      CMD_APP:          flags = CW_R48 | CW_CHK;
      default:          flags = '0;
    endcase
    if (flags == '0) return res;

    word = (32'(idx) << CwIdxShift) | flags;
    // switch function without app prefix reads a status block
    if (idx == CMD_SWITCH && !after_app) word = word | CW_ISDATA | CW_RD;
    if ((word & CW_ISDATA) != '0) word = word | CW_DMAEN;
    if (idx == CMD_IO_RW_EXT) begin
      if (!arg[31]) word = word | CW_RD;
      if (cnt != ONE_BLOCK) word = word | CW_MULTI | CW_BCNTEN;
    end

    res.clock_action = CLOCK_KEEP;
    res.width_action = WIDTH_KEEP;
    if (idx == CMD_GO_IDLE) res.clock_action = CLOCK_INIT;
    else if (idx == CMD_SELECT) res.clock_action = CLOCK_STD;

    if (idx == CMD_SWITCH) begin
      if (after_app) begin
        if (arg == APP_WIDTH_1BIT) res.width_action = WIDTH_1BIT;
        else if (arg == APP_WIDTH_4BIT) res.width_action = WIDTH_4BIT;
      end else if ((arg & SWITCH_HS_MASK) == SWITCH_HS_MATCH) begin
        res.clock_action = CLOCK_HIGH;
      end
    end else if (idx == CMD_IO_RW_DIRECT && (arg & BUS_IF_MASK) == BUS_IF_MATCH) begin
      if (arg[1:0] == 2'd0) res.width_action = WIDTH_1BIT;
      else if (arg[1:0] == 2'd2) res.width_action = WIDTH_4BIT;
    end

    res.command_word   = word;
    res.supported      = 1'b1;
    res.response_kind  = resp_kind_e'(word[17:16]);
    res.uses_data_line = ((word & CW_ISDATA) != '0) || ((word & CW_R48B) == CW_R48B);
    return res;
  endfunction

  always @(posedge clk_i) begin
    cmd_result_t want;
    cmd_result_t seen;
    if (!rst_ni) begin
      app_prefix = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        want = encode_command(cmd_index_i, argument_i, block_count_i, app_prefix);
        // unsupported commands leave the prefix alone
        if (want.supported) app_prefix = (cmd_index_i == CMD_APP);
        expected_results.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected: word=%h", $time,
                     command_word_i);
        end else begin
          want = expected_results.pop_front();
          seen.command_word   = command_word_i;
          seen.supported      = supported_i;
          seen.response_kind  = resp_kind_e'(response_kind_i);
          seen.uses_data_line = uses_data_line_i;
          seen.width_action   = width_act_e'(width_action_i);
          seen.clock_action   = clock_act_e'(clock_action_i);
          if (seen.command_word !== want.command_word ||
              seen.supported !== want.supported ||
              seen.response_kind !== want.response_kind ||
              seen.uses_data_line !== want.uses_data_line ||
              seen.width_action !== want.width_action ||
              seen.clock_action !== want.clock_action) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected word=%h sup=%b resp=%0d data=%b",
                        " width=%0d clock=%0d, got word=%h sup=%b resp=%0d data=%b",
                        " width=%0d clock=%0d"}, $time,
                       want.command_word, want.supported, want.response_kind,
                       want.uses_data_line, want.width_action, want.clock_action,
                       seen.command_word, seen.supported, seen.response_kind,
                       seen.uses_data_line, seen.width_action, seen.clock_action);
          end
        end
      end
    end
    pending_o        <= expected_results.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- bench/testbench.sv -----
// Testbench top for the SD command word encoder: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import sdcw_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomCmds   = 660;
  localparam int unsigned SettleCycles = 8;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [5:0]  cmd_index   = '0;
  logic [31:0] argument    = '0;
  logic [15:0] block_count = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [31:0] command_word;
  logic        supported;
  logic [1:0]  response_kind;
  logic        uses_data_line;
  logic [1:0]  width_action;
  logic [1:0]  clock_action;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned sender_idle_pct = 18;
  int unsigned recv_idle_pct   = 59;
  int unsigned cycle_count     = 0;

  sd_command_word_encoder_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_index_i      (cmd_index),
    .argument_i       (argument),
    .block_count_i    (block_count),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .command_word_o   (command_word),
    .supported_o      (supported),
    .response_kind_o  (response_kind),
    .uses_data_line_o (uses_data_line),
    .width_action_o   (width_action),
    .clock_action_o   (clock_action)
  );

  sdcw_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_index_i      (cmd_index),
    .argument_i       (argument),
    .block_count_i    (block_count),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .command_word_i   (command_word),
    .supported_i      (supported),
    .response_kind_i  (response_kind),
    .uses_data_line_i (uses_data_line),
    .width_action_i   (width_action),
    .clock_action_i   (clock_action),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Command with a table entry, by position in the table.
  function automatic logic [5:0] supported_cmd(input int unsigned n);
    case (n)
      0:       return CMD_GO_IDLE;
      1:       return CMD_ALL_SEND_CID;
      2:       return CMD_SEND_RCA;
      3:       return CMD_IO_OP_COND;
      4:       return CMD_SWITCH;
      5:       return CMD_SELECT;
      6:       return CMD_IF_COND;
      7:       return CMD_SEND_CSD;
      8:       return CMD_VOLT_SWITCH;
      9:       return CMD_STOP;
      10:      return CMD_STATUS;
      11:      return CMD_SET_BLOCKLEN;
      12:      return CMD_READ_SINGLE;
      13:      return CMD_READ_MULTI;
      14:      return CMD_WRITE_SINGLE;
      15:      return CMD_WRITE_MULTI;
      16:      return CMD_SD_OP_COND;
      17:      return CMD_IO_RW_DIRECT;
      18:      return CMD_IO_RW_EXT;
      default: return CMD_APP;
    endcase
  endfunction

  // Drive one command and hold it until the transfer; called at a rising edge.
  task automatic issue(input logic [5:0] idx, input logic [31:0] arg, input logic [15:0] cnt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd_index   <= idx;
    argument    <= arg;
    block_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_command();
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [15:0] cnt;
    int unsigned pick;
    idx  = supported_cmd($urandom_range(19));
    arg  = $urandom;
    cnt  = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      idx = 6'($urandom);
    end else if (pick < 40) begin
      // app prefix, then mostly a bus width command
      issue(CMD_APP, $urandom, 16'($urandom));
      if ($urandom_range(9) < 7) begin
        idx = CMD_SWITCH;
        case ($urandom_range(3))
          0:       arg = APP_WIDTH_1BIT;
          1:       arg = APP_WIDTH_4BIT;
          2:       arg = 32'($urandom_range(3));
          default: arg = $urandom;
        endcase
      end else if ($urandom_range(1) == 0) begin
        idx = 6'($urandom);
      end
    end else if (pick < 55) begin
      idx = CMD_SWITCH;
      if ($urandom_range(1) == 0) begin
        arg = (arg & ~SWITCH_HS_MASK) | SWITCH_HS_MATCH;
        // near miss on one of the matched bits
        if ($urandom_range(3) == 0) arg = arg ^ (32'd1 << (($urandom_range(4) == 4) ? 31 :
                                                     $urandom_range(3)));
      end
    end else if (pick < 70) begin
      idx = CMD_IO_RW_DIRECT;
      if ($urandom_range(3) != 0) begin
        arg = BUS_IF_MATCH | 32'($urandom_range(255));
        if ($urandom_range(1) == 0) arg = BUS_IF_MATCH | 32'($urandom_range(3));
      end
    end else if (pick < 85) begin
      idx = CMD_IO_RW_EXT;
      case ($urandom_range(4))
        0:       cnt = 16'd0;
        1:       cnt = ONE_BLOCK;
        2:       cnt = 16'd2;
        3:       cnt = 16'hFFFF;
        default: cnt = 16'($urandom);
      endcase
    end
    issue(idx, arg, cnt);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry with extreme argument and count
    for (int unsigned n = 0; n < 20; n++)
      issue(supported_cmd(n), n[0] ? 32'hFFFF_FFFF : 32'h0, n[1] ? 16'hFFFF : 16'h0);
    // unsupported index after the prefix must keep it for the following switch
    issue(6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    issue(CMD_SWITCH, APP_WIDTH_1BIT, 16'd0);
    issue(CMD_APP, 32'h0, 16'd0);
    issue(CMD_SWITCH, APP_WIDTH_4BIT, 16'd0);
    issue(CMD_SWITCH, SWITCH_HS_MATCH, 16'd0);
    issue(CMD_IO_RW_DIRECT, BUS_IF_MATCH | 32'd2, 16'd0);
    issue(CMD_IO_RW_DIRECT, BUS_IF_MATCH | 32'd1, 16'd0);
    issue(CMD_IO_RW_EXT, 32'h8000_0000, ONE_BLOCK);

    for (int unsigned k = 0; k < RandomCmds; k++) begin
      if (k == RandomCmds / 3) begin
        sender_idle_pct = 59;
        recv_idle_pct   = 18;
      end else if (k == 2 * RandomCmds / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      random_command();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sdcw_pkg.sv
hdl/sdcw_decode.sv
hdl/sd_command_word_encoder_top.sv
bench/sdcw_checker.sv
bench/testbench.sv
